>>> rtl/core/lbcs_pkg.sv
// Shared types, constants and pattern tables of the LED blink code sequencer.
// Used by lbcs_step and led_blink_code_sequencer_core; no dependencies.
package lbcs_pkg;

    localparam int CODE_W   = 3;
    localparam int LEN_W    = 16;
    localparam int IDX_W    = 4;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_CODES = 5;
    localparam int MAX_SEGS  = 16;

    // error codes
    localparam logic [CODE_W-1:0] ERR_NONE     = 3'd0;
    localparam logic [CODE_W-1:0] ERR_INIT     = 3'd1;
    localparam logic [CODE_W-1:0] ERR_RESOURCE = 3'd2;
    localparam logic [CODE_W-1:0] ERR_HARDFLT  = 3'd3;
    localparam logic [CODE_W-1:0] ERR_BADPARAM = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_CODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_MS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_MS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HIGH = 3'd4;

    // reset values
    localparam logic [CODE_W-1:0] RST_ERROR_CODE  = ERR_NONE;
    localparam logic [LEN_W-1:0]  RST_SHORT_MS    = 16'd200;
    localparam logic [LEN_W-1:0]  RST_LONG_MS     = 16'd800;
    localparam logic [LEN_W-1:0]  RST_CYCLE_MS    = 16'd2000;
    localparam logic              RST_ACTIVE_HIGH = 1'b1;

    typedef enum logic [1:0] {
        KIND_SHORT = 2'd0,
        KIND_LONG  = 2'd1,
        KIND_CYCLE = 2'd2
    } kind_t;

    typedef struct packed {
        logic  lit;
        kind_t kind;
    } seg_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [LEN_W-1:0] ticks;
    } seq_state_t;

    localparam seg_t S_ON  = '{lit: 1'b1, kind: KIND_SHORT};
    localparam seg_t S_OFF = '{lit: 1'b0, kind: KIND_SHORT};
    localparam seg_t L_ON  = '{lit: 1'b1, kind: KIND_LONG};
    localparam seg_t L_OFF = '{lit: 1'b0, kind: KIND_LONG};
    localparam seg_t GAP   = '{lit: 1'b0, kind: KIND_CYCLE};

    localparam logic [IDX_W:0] PAT_LEN [NUM_CODES] = '{5'd0, 5'd8, 5'd9, 5'd9, 5'd9};

    localparam seg_t SEG_TAB [NUM_CODES][MAX_SEGS] = '{
        '{default: S_OFF},
        '{0: S_ON, 1: S_OFF, 2: S_ON, 3: S_OFF, 4: S_ON, 5: S_OFF,
          6: L_ON, 7: GAP, default: S_OFF},
        '{0: S_ON, 1: S_OFF, 2: S_ON, 3: S_OFF, 4: S_ON, 5: S_OFF,
          6: S_ON, 7: S_OFF, 8: GAP, default: S_OFF},
        '{0: L_ON, 1: L_OFF, 2: S_ON, 3: S_OFF, 4: S_ON, 5: S_OFF,
          6: S_ON, 7: S_OFF, 8: GAP, default: S_OFF},
        '{0: L_ON, 1: L_OFF, 2: L_ON, 3: L_OFF, 4: S_ON, 5: S_OFF,
          6: S_ON, 7: S_OFF, 8: GAP, default: S_OFF}
    };

endpackage

>>> rtl/core/led_blink_code_sequencer_core.sv
// LED blink code sequencer: one word in per millisecond tick, one pin level out.
// Each accepted tick word's result is registered in the output register, valid from the next cycle.
// Throughput: 1 word per cycle; state updates in the accept cycle and the output
// register frees as it is taken. Reset (aresetn low, synchronous) loads default
// lengths, code none, active-high polarity, first segment, LED dark, output empty.
// Depends on lbcs_pkg and lbcs_step.
module led_blink_code_sequencer_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration
    input  logic                           cfg_we,
    input  logic [lbcs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lbcs_pkg::LEN_W-1:0]     cfg_wdata,
    // tick stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [0] tick, [7:1] zero
    // level stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata    // [0] pin_level, [1] led_lit
);

    logic [lbcs_pkg::CODE_W-1:0] error_code_reg;
    logic [lbcs_pkg::LEN_W-1:0]  short_ms_reg;
    logic [lbcs_pkg::LEN_W-1:0]  long_ms_reg;
    logic [lbcs_pkg::LEN_W-1:0]  cycle_ms_reg;
    logic                        active_high_reg;

    lbcs_pkg::seq_state_t        state_reg;
    lbcs_pkg::seq_state_t        state_next;
    logic                        led_reg;
    logic                        led_next;
    logic                        lit_step;

    logic                        m_tvalid_reg;
    logic [1:0]                  m_data_reg;
    logic                        accept;
    logic                        tick;

    assign tick     = s_tdata[0];
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, m_data_reg};

    lbcs_step u_step (
        .error_code (error_code_reg),
        .short_ms   (short_ms_reg),
        .long_ms    (long_ms_reg),
        .cycle_ms   (cycle_ms_reg),
        .state_cur  (state_reg),
        .state_nxt  (state_next),
        .lit        (lit_step)
    );

    // a word without tick holds state and repeats the present level
    assign led_next = tick ? lit_step : led_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            error_code_reg  <= lbcs_pkg::RST_ERROR_CODE;
            short_ms_reg    <= lbcs_pkg::RST_SHORT_MS;
            long_ms_reg     <= lbcs_pkg::RST_LONG_MS;
            cycle_ms_reg    <= lbcs_pkg::RST_CYCLE_MS;
            active_high_reg <= lbcs_pkg::RST_ACTIVE_HIGH;
            state_reg       <= '0;
            led_reg         <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (accept) begin
                if (tick) begin
                    state_reg <= state_next;
                end
                led_reg      <= led_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            if (cfg_we) begin
                case (cfg_index)
                    lbcs_pkg::CFG_ERROR_CODE: begin
                        // a new code restarts the pattern
                        if (cfg_wdata[lbcs_pkg::CODE_W-1:0] != error_code_reg) begin
                            state_reg <= '0;
                        end
                        error_code_reg <= cfg_wdata[lbcs_pkg::CODE_W-1:0];
                    end
                    lbcs_pkg::CFG_SHORT_MS:    short_ms_reg    <= cfg_wdata;
                    lbcs_pkg::CFG_LONG_MS:     long_ms_reg     <= cfg_wdata;
                    lbcs_pkg::CFG_CYCLE_MS:    cycle_ms_reg    <= cfg_wdata;
                    lbcs_pkg::CFG_ACTIVE_HIGH: active_high_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= {led_next, led_next ^ !active_high_reg};
        end
    end

endmodule

>>> rtl/core/lbcs_step.sv
// One tick of the blink sequencer: segment lookup, length load and countdown.
// Pure combinational; depends on lbcs_pkg.
module lbcs_step (
    input  logic [lbcs_pkg::CODE_W-1:0] error_code,
    input  logic [lbcs_pkg::LEN_W-1:0]  short_ms,
    input  logic [lbcs_pkg::LEN_W-1:0]  long_ms,
    input  logic [lbcs_pkg::LEN_W-1:0]  cycle_ms,
    input  lbcs_pkg::seq_state_t        state_cur,
    output lbcs_pkg::seq_state_t        state_nxt,
    output logic                        lit
);

    logic                        code_ok;
    logic [2:0]                  code_sel;
    logic [lbcs_pkg::IDX_W:0]    pat_len;
    logic [lbcs_pkg::IDX_W-1:0]  idx_eff;
    logic [lbcs_pkg::LEN_W-1:0]  ticks_eff;
    logic [lbcs_pkg::LEN_W-1:0]  seg_len;
    logic [lbcs_pkg::LEN_W-1:0]  ticks_dec;
    logic [lbcs_pkg::IDX_W:0]    idx_inc;
    lbcs_pkg::seg_t              seg;

    assign code_ok  = error_code inside {lbcs_pkg::ERR_INIT, lbcs_pkg::ERR_RESOURCE,
                                         lbcs_pkg::ERR_HARDFLT, lbcs_pkg::ERR_BADPARAM};
    assign code_sel = code_ok ? error_code : lbcs_pkg::ERR_NONE;
    assign pat_len  = lbcs_pkg::PAT_LEN[code_sel];

    always_comb begin
        // restart when the index has run past this pattern
        if ({1'b0, state_cur.idx} >= pat_len) begin
            idx_eff   = '0;
            ticks_eff = '0;
        end else begin
            idx_eff   = state_cur.idx;
            ticks_eff = state_cur.ticks;
        end

        seg = lbcs_pkg::SEG_TAB[code_sel][idx_eff];

        case (seg.kind)
            lbcs_pkg::KIND_SHORT: seg_len = short_ms;
            lbcs_pkg::KIND_LONG:  seg_len = long_ms;
            default:              seg_len = cycle_ms;
        endcase
        // a zero length acts as one tick
        if (seg_len == '0) begin
            seg_len = lbcs_pkg::LEN_W'(1);
        end

        ticks_dec = ((ticks_eff == '0) ? seg_len : ticks_eff) - lbcs_pkg::LEN_W'(1);
        idx_inc   = {1'b0, idx_eff} + (lbcs_pkg::IDX_W+1)'(1);

        state_nxt.ticks = ticks_dec;
        state_nxt.idx   = idx_eff;
        if (ticks_dec == '0) begin
            state_nxt.idx = (idx_inc >= pat_len) ? '0 : idx_inc[lbcs_pkg::IDX_W-1:0];
        end
        lit = seg.lit;

        // no pattern: stay dark and parked on the first segment
        if (!code_ok) begin
            state_nxt.idx   = '0;
            state_nxt.ticks = '0;
            lit             = 1'b0;
        end
    end

endmodule

>>> tb/sv/tb_led_blink_code_sequencer_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for led_blink_code_sequencer_core: tick words in, level words out.
// Keeps its own blink-code model, checks every level word and idles both streams at random.
// Depends on lbcs_pkg and the core RTL.
module tb_led_blink_code_sequencer_core;

    localparam int NUM_CFG_REGS  = 5;
    localparam int CFG_SLOTS     = 1 << lbcs_pkg::CFG_IDX_W;
    localparam int STALL_LIMIT   = 2000;
    localparam int REPORT_LIMIT  = 10;
    localparam int PHASE_ITEMS   = 360;

    typedef struct packed {
        logic lit;
        logic pin;
    } level_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [lbcs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [lbcs_pkg::LEN_W-1:0]     cfg_wdata = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata   = 8'h00;   // [0] tick, [7:1] zero
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [7:0]                     m_tdata;             // [0] pin_level, [1] led_lit

    // blink sequencer model: registers and pattern position
    logic [lbcs_pkg::CODE_W-1:0] code_q;
    logic [lbcs_pkg::LEN_W-1:0]  short_len;
    logic [lbcs_pkg::LEN_W-1:0]  long_len;
    logic [lbcs_pkg::LEN_W-1:0]  gap_len;
    logic                        lit_high;
    logic [lbcs_pkg::IDX_W-1:0]  seg_idx;
    logic [lbcs_pkg::LEN_W-1:0]  seg_left;
    logic                        led_on;

    level_t      expected_levels[$];
    int unsigned fail_count     = 0;
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles    = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    led_blink_code_sequencer_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int blink_length(input logic [lbcs_pkg::CODE_W-1:0] code);
        case (code)
            lbcs_pkg::ERR_INIT: return 8;
            lbcs_pkg::ERR_RESOURCE, lbcs_pkg::ERR_HARDFLT, lbcs_pkg::ERR_BADPARAM: return 9;
            default: return 0;
        endcase
    endfunction

    // even slots light the LED, the last slot is the closing gap
    function automatic lbcs_pkg::seg_t blink_segment(input logic [lbcs_pkg::CODE_W-1:0] code,
                                                     input logic [lbcs_pkg::IDX_W-1:0] idx);
        lbcs_pkg::seg_t seg;
        seg.lit  = ~idx[0];
        seg.kind = lbcs_pkg::KIND_SHORT;
        if (idx == blink_length(code) - 1) begin
            seg.lit  = 1'b0;
            seg.kind = lbcs_pkg::KIND_CYCLE;
        end else if ((code == lbcs_pkg::ERR_INIT && idx == 6) ||
                     (code == lbcs_pkg::ERR_HARDFLT && idx < 2) ||
                     (code == lbcs_pkg::ERR_BADPARAM && idx < 4)) begin
            seg.kind = lbcs_pkg::KIND_LONG;
        end
        return seg;
    endfunction

    function automatic logic [lbcs_pkg::LEN_W-1:0] segment_ticks(input lbcs_pkg::kind_t kind);
        logic [lbcs_pkg::LEN_W-1:0] n;
        case (kind)
            lbcs_pkg::KIND_SHORT: n = short_len;
            lbcs_pkg::KIND_LONG:  n = long_len;
            default:              n = gap_len;
        endcase
        return (n == '0) ? 16'd1 : n;
    endfunction

    function automatic void blink_reset();
        code_q    = lbcs_pkg::RST_ERROR_CODE;
        short_len = lbcs_pkg::RST_SHORT_MS;
        long_len  = lbcs_pkg::RST_LONG_MS;
        gap_len   = lbcs_pkg::RST_CYCLE_MS;
        lit_high  = lbcs_pkg::RST_ACTIVE_HIGH;
        seg_idx   = '0;
        seg_left  = '0;
        led_on    = 1'b0;
    endfunction

    function automatic void blink_write(input logic [lbcs_pkg::CFG_IDX_W-1:0] idx,
                                        input logic [lbcs_pkg::LEN_W-1:0] data);
        case (idx)
            lbcs_pkg::CFG_ERROR_CODE: begin
                // a different code restarts the pattern, the LED keeps its level
                if (data[lbcs_pkg::CODE_W-1:0] != code_q) begin
                    seg_idx  = '0;
                    seg_left = '0;
                end
                code_q = data[lbcs_pkg::CODE_W-1:0];
            end
            lbcs_pkg::CFG_SHORT_MS:    short_len = data;
            lbcs_pkg::CFG_LONG_MS:     long_len  = data;
            lbcs_pkg::CFG_CYCLE_MS:    gap_len   = data;
            lbcs_pkg::CFG_ACTIVE_HIGH: lit_high  = data[0];
            default: ;
        endcase
    endfunction

    function automatic level_t blink_advance(input logic tick);
        level_t         lv;
        lbcs_pkg::seg_t seg;
        int             len;
        if (tick) begin
            len = blink_length(code_q);
            if (len == 0) begin
                seg_idx  = '0;
                seg_left = '0;
                led_on   = 1'b0;
            end else begin
                if (seg_idx >= len) begin
                    seg_idx  = '0;
                    seg_left = '0;
                end
                seg = blink_segment(code_q, seg_idx);
                if (seg_left == '0)
                    seg_left = segment_ticks(seg.kind);
                led_on   = seg.lit;
                seg_left = seg_left - 1'b1;
                if (seg_left == '0) begin
                    seg_idx = seg_idx + 1'b1;
                    if (seg_idx >= len)
                        seg_idx = '0;
                end
            end
        end
        lv.lit = led_on;
        lv.pin = led_on ~^ lit_high;
        return lv;
    endfunction

    task automatic send_tick(input logic tick);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {7'b0, tick};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        expected_levels.push_back(blink_advance(tick));
    endtask

    // drop valid and let every outstanding level word come back
    task automatic settle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (expected_levels.size() != 0)
            @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [lbcs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lbcs_pkg::LEN_W-1:0] data);
        settle();
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(posedge aclk);
        blink_write(idx, data);
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [lbcs_pkg::LEN_W-1:0] pick_length();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return lbcs_pkg::LEN_W'($urandom_range(0, 4));
        else if (r < 8)
            return lbcs_pkg::LEN_W'($urandom_range(5, 12));
        else if (r == 8)
            return 16'hFFFF;
        return lbcs_pkg::LEN_W'($urandom_range(0, 65535));
    endfunction

    task automatic test_dark_after_reset();
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        // polarity flips the pin on the next level word, even without a tick
        write_reg(lbcs_pkg::CFG_ACTIVE_HIGH, 16'h0000);
        send_tick(1'b0);
    endtask

    task automatic test_zero_lengths();
        write_reg(lbcs_pkg::CFG_SHORT_MS, 16'h0000);
        write_reg(lbcs_pkg::CFG_LONG_MS, 16'h0000);
        write_reg(lbcs_pkg::CFG_CYCLE_MS, 16'h0000);
        write_reg(lbcs_pkg::CFG_ERROR_CODE, {13'b0, lbcs_pkg::ERR_INIT});
        repeat (5) send_tick(1'b1);
        send_tick(1'b0);
        repeat (4) send_tick(1'b1);
        // same code again must not restart
        write_reg(lbcs_pkg::CFG_ERROR_CODE, {13'h1FFF, lbcs_pkg::ERR_INIT});
        send_tick(1'b1);
    endtask

    task automatic test_unknown_code();
        write_reg(lbcs_pkg::CFG_ERROR_CODE, 16'h0007);
        send_tick(1'b1);
        send_tick(1'b1);
    endtask

    task automatic test_long_extremes();
        write_reg(lbcs_pkg::CFG_SHORT_MS, 16'hFFFF);
        write_reg(lbcs_pkg::CFG_LONG_MS, 16'hFFFF);
        write_reg(lbcs_pkg::CFG_CYCLE_MS, 16'hFFFF);
        write_reg(lbcs_pkg::CFG_ACTIVE_HIGH, 16'hFFFF);
        write_reg(lbcs_pkg::CFG_ERROR_CODE, {13'b0, lbcs_pkg::ERR_HARDFLT});
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
    endtask

    task automatic test_unused_index();
        for (int i = NUM_CFG_REGS; i < CFG_SLOTS; i++)
            write_reg(lbcs_pkg::CFG_IDX_W'(i), 16'h0000);
        send_tick(1'b1);
    endtask

    task automatic test_random_phase(input int unsigned idle_pct, input int unsigned stall_pct);
        int sent;
        int run_len;
        sent           = 0;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (sent < PHASE_ITEMS) begin
            if ($urandom_range(0, 9) < 7) begin
                if ($urandom_range(0, 9) < 8)
                    write_reg(lbcs_pkg::CFG_ERROR_CODE,
                              {(lbcs_pkg::LEN_W-lbcs_pkg::CODE_W)'($urandom),
                               lbcs_pkg::CODE_W'($urandom_range(1, 4))});
                else
                    write_reg(lbcs_pkg::CFG_ERROR_CODE, lbcs_pkg::LEN_W'($urandom));
            end
            if ($urandom_range(0, 1)) write_reg(lbcs_pkg::CFG_SHORT_MS, pick_length());
            if ($urandom_range(0, 1)) write_reg(lbcs_pkg::CFG_LONG_MS, pick_length());
            if ($urandom_range(0, 1)) write_reg(lbcs_pkg::CFG_CYCLE_MS, pick_length());
            if ($urandom_range(0, 9) < 3)
                write_reg(lbcs_pkg::CFG_ACTIVE_HIGH, lbcs_pkg::LEN_W'($urandom));
            if ($urandom_range(0, 9) == 0)
                write_reg(lbcs_pkg::CFG_IDX_W'($urandom_range(NUM_CFG_REGS, CFG_SLOTS - 1)),
                          lbcs_pkg::LEN_W'($urandom));
            run_len = $urandom_range(20, 60);
            repeat (run_len) send_tick($urandom_range(0, 9) != 0);
            sent += run_len;
        end
        settle();
    endtask

    // receiver: stall at random, outputs change on the falling edge
    always @(negedge aclk) begin
        if (aresetn)
            m_tready = ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // level word checker and watchdog
    always @(posedge aclk) begin
        level_t want;
        if (m_tvalid && m_tready && aresetn) begin
            if (expected_levels.size() == 0) begin
                fail_count++;
                if (mismatch_count < REPORT_LIMIT)
                    $display("unexpected level word: pin %0b lit %0b", m_tdata[0], m_tdata[1]);
                mismatch_count++;
            end else begin
                want = expected_levels.pop_front();
                if (m_tdata[0] !== want.pin || m_tdata[1] !== want.lit) begin
                    fail_count++;
                    if (mismatch_count < REPORT_LIMIT)
                        $display("level mismatch: expected pin %0b lit %0b, got pin %0b lit %0b",
                                 want.pin, want.lit, m_tdata[0], m_tdata[1]);
                    mismatch_count++;
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("led_blink_code_sequencer_core: mismatch");
            $finish;
        end
    end

    initial begin
        blink_reset();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_dark_after_reset();
        test_zero_lengths();
        test_unknown_code();
        test_long_extremes();
        test_unused_index();
        test_random_phase(0, 0);
        test_random_phase(52, 0);
        test_random_phase(0, 52);
        test_random_phase(37, 37);

        repeat (5) @(posedge aclk);
        fail_count += expected_levels.size();
        if (fail_count == 0)
            $display("led_blink_code_sequencer_core: match");
        else
            $display("led_blink_code_sequencer_core: mismatch");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/lbcs_pkg.sv
rtl/core/lbcs_step.sv
rtl/core/led_blink_code_sequencer_core.sv
tb/sv/tb_led_blink_code_sequencer_core.sv
